### hw/rtl/sis_pkg.sv
// ----------------------------------------------------------------------------
// sis_pkg: shared types and constants for the stream interleave scheduler
// Function codes, action codes and the controller-to-datapath command struct.
// ----------------------------------------------------------------------------
package sis_pkg;

    localparam int unsigned FUNC_W  = 2;
    localparam int unsigned SID_W   = 3;
    localparam int unsigned RATE_W  = 32;
    localparam int unsigned PRE_W   = 32;
    localparam int unsigned IV_W    = 24;
    localparam int unsigned PUSH_W  = 31;
    localparam int unsigned WR_W    = 48;
    localparam int unsigned FC_W    = 32;

    // Interval value meaning "every frame": no rounding.
    localparam logic [IV_W-1:0] IV_ONE_FRAME = 24'd65536;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_REQUEST = 2'd0,
        FUNC_SETUP   = 2'd1,
        FUNC_END     = 2'd2,
        FUNC_RATE    = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ACT_ACK   = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_FINISH = 2'd2,
        ACT_STALL = 2'd3
    } action_t;

    // Commands from controller to datapath.
    typedef struct packed {
        logic setup;       // load stream registers from the captured item
        logic end_stream;  // retire the captured stream
        logic queue_rate;  // store a pending rate
        logic eval_start;  // launch target evaluation of stream eval_idx
        logic eval_store;  // write back due count of the evaluated stream
        logic advance;     // bump frame count and apply pending rates
        logic push;        // hand out samples from stream eval_idx
        logic [3:0] eval_idx;
    } sis_cmd_t;

    // Status from datapath to controller.
    typedef struct packed {
        logic eval_done;   // due count of eval_idx is ready
        logic due_nz;      // evaluated due count is nonzero
        logic cur_due_nz;  // stored due count of eval_idx is nonzero
    } sis_sts_t;

endpackage

### hw/rtl/sis_div.sv
// ----------------------------------------------------------------------------
// sis_div: radix-2 restoring divider for 49-bit by 24-bit remainders
// Returns the remainder of num / den, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module sis_div
    import sis_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [WR_W:0]   num,
    input  logic [IV_W-1:0] den,
    output logic            done,
    output logic [IV_W-1:0] rem
);

    logic [WR_W:0]   num_reg, num_next;
    logic [IV_W:0]   rem_reg, rem_next;
    logic [5:0]      cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [IV_W:0]   trial;

    assign trial = {rem_reg[IV_W-1:0], num_reg[WR_W]};

    // Shift in one numerator bit and subtract when it fits.
    always_comb
    begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            num_next  = num;
            rem_next  = '0;
            cnt_next  = 6'(WR_W + 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[WR_W-1:0], 1'b0};
            rem_next = (trial >= {1'b0, den}) ? trial - {1'b0, den} : trial;
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg[IV_W-1:0];

endmodule

### hw/rtl/sis_datapath.sv
// ----------------------------------------------------------------------------
// sis_datapath: per-stream registers and the frame target unit
// Holds stream state, evaluates ceil(rate x offset) and hands out samples.
// ----------------------------------------------------------------------------
module sis_datapath
    import sis_pkg::*;
#(
    parameter int unsigned STREAMS = 8,
    parameter int unsigned IDX_W   = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  sis_cmd_t          cmd,
    input  logic [SID_W-1:0]  in_stream,
    input  logic [RATE_W-1:0] in_rate,
    input  logic [PRE_W-1:0]  in_pre,
    input  logic [IV_W-1:0]   in_iv,
    input  logic [PUSH_W-1:0] in_push,
    output sis_sts_t          sts,
    output logic [PUSH_W-1:0] push_n,
    output logic [STREAMS-1:0] active
);

    typedef enum logic [5:0] {
        EV_IDLE = 6'b000001,
        EV_DIV  = 6'b000010,
        EV_OFF  = 6'b000100,
        EV_MUL1 = 6'b001000,
        EV_MUL2 = 6'b010000,
        EV_SUM  = 6'b100000
    } ev_state_t;

    logic [STREAMS-1:0]  active_reg;
    logic [STREAMS-1:0]  pend_v_reg;
    logic [RATE_W-1:0]   rate_reg   [STREAMS];
    logic [RATE_W-1:0]   pend_reg   [STREAMS];
    logic [PRE_W-1:0]    pre_reg    [STREAMS];
    logic [IV_W-1:0]     iv_reg     [STREAMS];
    logic [PUSH_W-1:0]   lim_reg    [STREAMS];
    logic [WR_W-1:0]     wr_reg     [STREAMS];
    logic [PUSH_W-1:0]   due_reg    [STREAMS];
    logic [FC_W-1:0]     fc_reg;

    ev_state_t           ev_reg;
    logic [IDX_W-1:0]    ev_idx_reg;
    logic [WR_W:0]       mf_reg;       // rounded frame offset, up to 2^48 + 2^24
    logic [49:0]         off_reg;      // signed offset
    logic                neg_reg;
    logic [63:0]         plo_reg;      // lo * rate
    logic [49:0]         phi_reg;      // hi * rate (hi < 2^18)
    logic [PUSH_W-1:0]   due_eval_reg;
    logic                done_reg;

    logic                div_start, div_done;
    logic [IV_W-1:0]     div_rem;
    logic [IDX_W-1:0]    ev_sel;
    logic [SID_W-1:0]    ev_s;
    logic [SID_W-1:0]    cs;
    logic [IV_W-1:0]     iv_s;
    logic                round_en;
    logic [49:0]         mag;
    logic [WR_W+2:0]     mf_up;
    logic [63:0]         q;
    logic [64:0]         need;
    logic [PUSH_W-1:0]   lim_c;
    logic [PUSH_W-1:0]   due_c;

    // While idle, look at the stream being launched; after that, the captured one.
    assign ev_sel   = (ev_reg == EV_IDLE) ? cmd.eval_idx : ev_idx_reg;
    assign ev_s     = ev_sel[SID_W-1:0];
    assign cs       = cmd.eval_idx[SID_W-1:0];
    assign iv_s     = iv_reg[ev_s];
    assign round_en = (iv_s != IV_ONE_FRAME) && (iv_s != '0);
    assign mf_up    = {3'b0, fc_reg, 16'b0} + {27'b0, iv_s} - 51'd1;

    sis_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (mf_up[WR_W:0]),
        .den   (iv_s),
        .done  (div_done),
        .rem   (div_rem)
    );

    assign div_start = (ev_reg == EV_IDLE) && cmd.eval_start && round_en;
    assign mag = neg_reg ? (50'd0 - off_reg) : off_reg;
    assign q   = {14'b0, phi_reg} + {32'b0, plo_reg[63:32]} +
                 {63'b0, (!neg_reg && plo_reg[31:0] != '0)};

    // Signed need = +-q minus samples written, clamped to [0, 2^31-1].
    always_comb
    begin
        need = {1'b0, q} - {17'b0, wr_reg[ev_s]};
        if (neg_reg || q <= {16'b0, wr_reg[ev_s]})
            due_c = '0;
        else if (need[63:31] != '0)
            due_c = '1;
        else
            due_c = need[PUSH_W-1:0];
    end

    // Evaluation sequencer: round offset when needed, two multiplies, then clamp.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_reg   <= EV_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (ev_reg)
                EV_IDLE: if (cmd.eval_start) ev_reg <= round_en ? EV_DIV : EV_OFF;
                EV_DIV:  if (div_done) ev_reg <= EV_OFF;
                EV_OFF:  ev_reg <= EV_MUL1;
                EV_MUL1: ev_reg <= EV_MUL2;
                EV_MUL2: ev_reg <= EV_SUM;
                EV_SUM:
                begin
                    ev_reg   <= EV_IDLE;
                    done_reg <= 1'b1;
                end
                default: ev_reg <= EV_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (ev_reg)
            EV_IDLE:
            begin
                ev_idx_reg <= cmd.eval_idx;
                mf_reg     <= {1'b0, fc_reg, 16'b0};
            end
            EV_DIV:
                if (div_done)
                    mf_reg <= mf_up[WR_W:0] - {25'b0, div_rem};
            EV_OFF:
            begin
                off_reg <= {1'b0, mf_reg} + {{18{pre_reg[ev_s][PRE_W-1]}}, pre_reg[ev_s]};
                neg_reg <= pre_reg[ev_s][PRE_W-1] &&
                           ({1'b0, mf_reg} < {18'b0, 32'd0 - pre_reg[ev_s]});
            end
            EV_MUL1: plo_reg <= {32'b0, mag[31:0]} * {32'b0, rate_reg[ev_s]};
            EV_MUL2: phi_reg <= 50'({32'b0, mag[49:32]} * {18'b0, rate_reg[ev_s]});
            EV_SUM:  due_eval_reg <= due_c;
            default: ;
        endcase
    end

    assign lim_c  = (lim_reg[cs] == '0) ? PUSH_W'(1) : lim_reg[cs];
    assign push_n = (due_reg[cs] < lim_c) ? due_reg[cs] : lim_c;

    // Per-stream state updates.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
            pend_v_reg <= '0;
            fc_reg     <= '0;
            for (int i = 0; i < STREAMS; i++)
                due_reg[i] <= '0;
        end
        else
        begin
            if (cmd.setup)
            begin
                active_reg[in_stream] <= 1'b1;
                pend_v_reg[in_stream] <= 1'b0;
                due_reg[in_stream]    <= '0;
            end
            if (cmd.end_stream)
            begin
                active_reg[in_stream] <= 1'b0;
                due_reg[in_stream]    <= '0;
            end
            if (cmd.queue_rate)
                pend_v_reg[in_stream] <= 1'b1;
            if (cmd.eval_store)
                due_reg[cs] <= due_eval_reg;
            if (cmd.push)
                due_reg[cs] <= due_reg[cs] - push_n;
            if (cmd.advance)
            begin
                fc_reg     <= fc_reg + 32'd1;
                pend_v_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.setup)
        begin
            rate_reg[in_stream] <= in_rate;
            pre_reg[in_stream]  <= in_pre;
            iv_reg[in_stream]   <= in_iv;
            lim_reg[in_stream]  <= in_push;
            wr_reg[in_stream]   <= '0;
        end
        if (cmd.queue_rate)
            pend_reg[in_stream] <= in_rate;
        if (cmd.push)
            wr_reg[cs] <= wr_reg[cs] + {17'b0, push_n};
        if (cmd.advance)
            for (int i = 0; i < STREAMS; i++)
                if (pend_v_reg[i])
                    rate_reg[i] <= pend_reg[i];
    end

    assign sts.eval_done  = done_reg;
    assign sts.due_nz     = due_eval_reg != '0;
    assign sts.cur_due_nz = due_reg[cs] != '0;
    assign active         = active_reg;

endmodule

### hw/rtl/sis_ctrl.sv
// ----------------------------------------------------------------------------
// sis_ctrl: request sequencer for the stream interleave scheduler
// Walks the refill and scan loops and issues datapath commands.
// ----------------------------------------------------------------------------
module sis_ctrl
    import sis_pkg::*;
#(
    parameter int unsigned STREAMS             = 8,
    parameter int unsigned FRAME_ADVANCE_LIMIT = 4096,
    parameter int unsigned IDX_W               = 4
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [FUNC_W-1:0]  func,
    input  logic [SID_W-1:0]   stream,
    input  logic               ilv_en,
    input  sis_sts_t           sts,
    input  logic [PUSH_W-1:0]  push_n,
    input  logic [STREAMS-1:0] active,
    output sis_cmd_t           cmd,
    output logic               busy,
    output logic               done,
    output logic [1:0]         action,
    output logic [SID_W-1:0]   stream_id,
    output logic [PUSH_W-1:0]  samples
);

    localparam int unsigned ADV_W = $clog2(FRAME_ADVANCE_LIMIT + 1);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_REFILL = 7'b0000010,
        ST_EVWAIT = 7'b0000100,
        ST_EVNEXT = 7'b0001000,
        ST_FRAME  = 7'b0010000,
        ST_SCAN   = 7'b0100000,
        ST_RESP   = 7'b1000000
    } state_t;

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   sp_reg, sp_next;
    logic [IDX_W-1:0]   solo_reg, solo_next;
    logic [IDX_W:0]     total_reg, total_next;
    logic [IDX_W-1:0]   ri_reg, ri_next;
    logic [IDX_W:0]     feed_reg, feed_next;
    logic [ADV_W-1:0]   adv_reg, adv_next;
    logic               pass_reg, pass_next;
    logic               pushed_reg, pushed_next;
    logic [1:0]         act_reg, act_next;
    logic [SID_W-1:0]   sid_reg, sid_next;
    logic [PUSH_W-1:0]  smp_reg, smp_next;
    logic               done_reg, done_next;
    logic               acc;
    logic               in_range;
    logic [STREAMS-1:0] act_after;
    logic [IDX_W-1:0]   solo_scan;
    logic               solo_found;

    assign acc      = start && (state_reg == ST_IDLE);
    assign in_range = {1'b0, stream} < (IDX_W+1)'(STREAMS);

    // Next active stream at or above the solo pointer after an end.
    always_comb
    begin
        act_after = active;
        if (in_range)
            act_after[stream] = 1'b0;
        solo_scan  = solo_reg;
        solo_found = 1'b0;
        for (int i = 0; i < STREAMS; i++)
            if (!solo_found && IDX_W'(i) >= solo_reg && act_after[i])
            begin
                solo_scan  = IDX_W'(i);
                solo_found = 1'b1;
            end
        if (!solo_found)
            solo_scan = IDX_W'(STREAMS);
    end

    always_comb
    begin
        state_next  = state_reg;
        sp_next     = sp_reg;
        solo_next   = solo_reg;
        total_next  = total_reg;
        ri_next     = ri_reg;
        feed_next   = feed_reg;
        adv_next    = adv_reg;
        pass_next   = pass_reg;
        pushed_next = pushed_reg;
        act_next    = act_reg;
        sid_next    = sid_reg;
        smp_next    = smp_reg;
        done_next   = 1'b0;
        cmd         = '0;
        cmd.eval_idx = ri_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (acc)
                begin
                    act_next = ACT_ACK;
                    sid_next = '0;
                    smp_next = '0;
                    state_next = ST_RESP;
                    if (func == FUNC_REQUEST)
                    begin
                        if (total_reg == '0)
                            act_next = ACT_FINISH;
                        else
                        begin
                            pass_next  = 1'b0;
                            pushed_next = 1'b0;
                            adv_next   = '0;
                            state_next = ST_SCAN;
                        end
                    end
                    else if (in_range)
                    begin
                        unique case (func)
                            FUNC_SETUP:
                            begin
                                cmd.setup = 1'b1;
                                if (!active[stream])
                                    total_next = total_reg + 1'b1;
                            end
                            FUNC_END:
                                if (active[stream])
                                begin
                                    cmd.end_stream = 1'b1;
                                    total_next = total_reg - 1'b1;
                                    solo_next  = solo_scan;
                                end
                            FUNC_RATE: cmd.queue_rate = 1'b1;
                            default: ;
                        endcase
                    end
                end
            end
            ST_SCAN:
            begin
                // At pointer zero, refill first (once per request).
                cmd.eval_idx = sp_reg;
                if (sp_reg == '0 && !pushed_reg)
                begin
                    ri_next    = solo_reg;
                    feed_next  = '0;
                    state_next = ST_REFILL;
                end
                else if (sp_reg >= IDX_W'(STREAMS) ||
                         (!ilv_en && sp_reg > solo_reg))
                begin
                    sp_next = '0;
                    if (pushed_reg || pass_reg)
                    begin
                        act_next   = ACT_STALL;
                        state_next = ST_RESP;
                    end
                    else
                        pass_next = 1'b1;
                end
                else if (sts.cur_due_nz)
                begin
                    cmd.push   = 1'b1;
                    act_next   = ACT_WRITE;
                    sid_next   = sp_reg[SID_W-1:0];
                    smp_next   = push_n;
                    state_next = ST_RESP;
                end
                else
                    sp_next = sp_reg + 1'b1;
            end
            ST_REFILL:
            begin
                if (ri_reg >= IDX_W'(STREAMS))
                    state_next = ST_FRAME;
                else if (!active[ri_reg[SID_W-1:0]])
                    ri_next = ri_reg + 1'b1;
                else
                begin
                    cmd.eval_start = 1'b1;
                    state_next = ST_EVWAIT;
                end
            end
            ST_EVWAIT:
                if (sts.eval_done)
                begin
                    cmd.eval_store = 1'b1;
                    if (sts.due_nz)
                        feed_next = feed_reg + 1'b1;
                    state_next = ST_EVNEXT;
                end
            ST_EVNEXT:
            begin
                ri_next    = ilv_en ? ri_reg + 1'b1 : IDX_W'(STREAMS);
                state_next = ST_REFILL;
            end
            ST_FRAME:
            begin
                if (feed_reg != '0)
                begin
                    pushed_next = 1'b1;
                    if (!ilv_en)
                        sp_next = solo_reg;
                    state_next = ST_SCAN;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    adv_next = adv_reg + 1'b1;
                    if (adv_reg + 1'b1 >= ADV_W'(FRAME_ADVANCE_LIMIT))
                    begin
                        act_next   = ACT_STALL;
                        state_next = ST_RESP;
                    end
                    else
                    begin
                        ri_next    = solo_reg;
                        state_next = ST_REFILL;
                    end
                end
            end
            ST_RESP:
            begin
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            sp_reg     <= '0;
            solo_reg   <= '0;
            total_reg  <= '0;
            ri_reg     <= '0;
            feed_reg   <= '0;
            adv_reg    <= '0;
            pass_reg   <= 1'b0;
            pushed_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            sp_reg     <= sp_next;
            solo_reg   <= solo_next;
            total_reg  <= total_next;
            ri_reg     <= ri_next;
            feed_reg   <= feed_next;
            adv_reg    <= adv_next;
            pass_reg   <= pass_next;
            pushed_reg <= pushed_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg <= act_next;
        sid_reg <= sid_next;
        smp_reg <= smp_next;
    end

    assign busy      = state_reg != ST_IDLE;
    assign done      = done_reg;
    assign action    = act_reg;
    assign stream_id = sid_reg;
    assign samples   = smp_reg;

endmodule

### hw/rtl/stream_interleave_scheduler.sv
// ----------------------------------------------------------------------------
// stream_interleave_scheduler: top level
// Schedules sample writes of up to STREAMS streams against a frame clock.
//
//   channel  | handshake          | payload
//   ---------+--------------------+----------------------------------------
//   command  | start / busy       | func stream samples_per_frame preload_
//            |                    | microframes interval_microframes max_push
//   result   | done (one cycle)   | action stream_id samples
//   config   | APB psel/penable   | interleave_enable at address 0
//
// Set up, end and rate change respond straight from idle. A request evaluates
// active streams from the solo one up (only it with interleave off) through a
// remainder divider, skipped when no rounding is needed, and two multiplies,
// per frame tried, up to FRAME_ADVANCE_LIMIT frames. Reset clears all control
// state; no clearing pass. The receiver cannot stall: done pulses for one cycle.
// ----------------------------------------------------------------------------
module stream_interleave_scheduler
    import sis_pkg::*;
#(
    parameter int unsigned STREAMS             = 8,
    parameter int unsigned FRAME_ADVANCE_LIMIT = 4096
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [1:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  logic                 start,
    output logic                 busy,
    input  logic [FUNC_W-1:0]    func,
    input  logic [SID_W-1:0]     stream,
    input  logic [RATE_W-1:0]    samples_per_frame,
    input  logic signed [PRE_W-1:0] preload_microframes,
    input  logic [IV_W-1:0]      interval_microframes,
    input  logic [PUSH_W-1:0]    max_push,
    output logic                 done,
    output logic [1:0]           action,
    output logic [SID_W-1:0]     stream_id,
    output logic [PUSH_W-1:0]    samples
);

    localparam int unsigned IDX_W = $clog2(STREAMS + 1);

    logic               ilv_en_reg;
    sis_cmd_t           cmd;
    sis_sts_t           sts;
    logic [PUSH_W-1:0]  push_n;
    logic [STREAMS-1:0] active;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ilv_en_reg <= 1'b1;
        else if (psel && penable && pwrite && paddr == 2'd0)
            ilv_en_reg <= pwdata[0];
    end

    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {31'b0, ilv_en_reg} : 32'b0;

    sis_ctrl #(
        .STREAMS             (STREAMS),
        .FRAME_ADVANCE_LIMIT (FRAME_ADVANCE_LIMIT),
        .IDX_W               (IDX_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .func      (func),
        .stream    (stream),
        .ilv_en    (ilv_en_reg),
        .sts       (sts),
        .push_n    (push_n),
        .active    (active),
        .cmd       (cmd),
        .busy      (busy),
        .done      (done),
        .action    (action),
        .stream_id (stream_id),
        .samples   (samples)
    );

    sis_datapath #(
        .STREAMS (STREAMS),
        .IDX_W   (IDX_W)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_stream (stream),
        .in_rate   (samples_per_frame),
        .in_pre    (preload_microframes),
        .in_iv     (interval_microframes),
        .in_push   (max_push),
        .sts       (sts),
        .push_n    (push_n),
        .active    (active)
    );

endmodule

### hw/rtl/sis_checker.sv
// ----------------------------------------------------------------------------
// sis_checker: port-level checks for the stream interleave scheduler
// Watches command acceptance and result strobes.
// ----------------------------------------------------------------------------
module sis_checker
    import sis_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 done,
    input logic [1:0]           action,
    input logic [SID_W-1:0]     stream_id,
    input logic [PUSH_W-1:0]    samples
);

    // An accepted item makes the block busy.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy) else $error("not busy after accept");

    // Result strobe is a single cycle.
    a_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done longer than one cycle");

    // Writes always carry samples.
    a_write: assert property (@(posedge clk) disable iff (!rst_n)
        done && action == ACT_WRITE |-> samples != '0) else $error("empty write");

    // Non-write results carry zero payload.
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && action != ACT_WRITE |-> samples == '0 && stream_id == '0)
        else $error("payload on non-write");

endmodule

bind stream_interleave_scheduler sis_checker u_sis_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .action    (action),
    .stream_id (stream_id),
    .samples   (samples)
);
